// ===== rtl/core/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the stable pivot partition block.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int HIGH_DEPTH = 63;
    localparam int FILL_W     = $clog2(HIGH_DEPTH + 1);
    localparam int ADDR_W     = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
    localparam int TALLY_W    = 16;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [FILL_W-1:0]            fill_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [TALLY_W-1:0]           tally_t;

    localparam fill_t  FillMax  = FILL_W'(HIGH_DEPTH);
    localparam tally_t TallyMax = '1;

    // Port controls of the high-element buffer
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        logic  rd_en;
        addr_t rd_addr;
    } buf_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spp_if.sv =====
// ----------------------------------------------------------------------------
// spp_if
// Valid/ready channels of the stable pivot partition block: input items,
// result items and the pivot write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface spp_in_if;
    import spp_pkg::*;

    logic  valid;
    logic  ready;
    data_t sample;
    logic  final_item;

    modport source (output valid, sample, final_item, input ready);
    modport sink   (input valid, sample, final_item, output ready);
endinterface

interface spp_out_if;
    import spp_pkg::*;

    logic   valid;
    logic   ready;
    data_t  element;
    logic   above_pivot;
    logic   end_of_run;
    tally_t low_total;
    logic   overflowed;

    modport source (output valid, element, above_pivot, end_of_run, low_total, overflowed,
                    input ready);
    modport sink   (input valid, element, above_pivot, end_of_run, low_total, overflowed,
                    output ready);
endinterface

interface spp_cfg_if;
    import spp_pkg::*;

    logic  valid;
    logic  ready;
    data_t pivot;

    modport source (output valid, pivot, input ready);
    modport sink   (input valid, pivot, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spp_high_buf.sv =====
// ----------------------------------------------------------------------------
// spp_high_buf
// Buffer of elements above the pivot: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_high_buf (
    input  wire                logic clk,
    input  wire spp_pkg::buf_ctrl_t ctrl,
    input  wire spp_pkg::data_t     wr_data,
    output      spp_pkg::data_t     rd_data
);
    import spp_pkg::*;

    data_t mem [HIGH_DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stable_pivot_partition.sv =====
// ----------------------------------------------------------------------------
// stable_pivot_partition
// Streams a signed array and emits its stable partition around the pivot.
// ----------------------------------------------------------------------------
// Each element is compared with the pivot as it arrives, one item per cycle
// while the output is not stalled. An element at or below the pivot goes
// straight to the output register; an element above it is written into a
// 63-entry buffer memory (further high elements are dropped and flagged).
// After the last item the buffer is replayed in arrival order through the
// registered read port, one element per cycle when the output is not
// stalled; no item is taken during that replay. The last result of each
// array carries end_of_run, the count of low elements (saturating at 65535)
// and the overflow flag. The pivot may be written at any time the block is
// idle; it resets to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_pivot_partition (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spp_in_if.sink     items,
    spp_out_if.source  results,
    spp_cfg_if.sink    cfg
);
    import spp_pkg::*;

    typedef enum logic {ST_RUN, ST_FLUSH} st_t;

    st_t       state_reg, state_next;
    data_t     pivot_reg, pivot_next;
    fill_t     fill_reg, fill_next;
    tally_t    tally_reg, tally_next;
    logic      drop_reg, drop_next;
    fill_t     rd_idx_reg, rd_idx_next;
    logic      pend_reg, pend_next;
    logic      pend_last_reg, pend_last_next;

    logic      out_valid_reg, out_valid_next;
    data_t     out_elem_reg, out_elem_next;
    logic      out_above_reg, out_above_next;
    logic      out_end_reg, out_end_next;
    tally_t    out_total_reg, out_total_next;
    logic      out_ovf_reg, out_ovf_next;

    buf_ctrl_t buf_ctrl;
    data_t     rd_data;

    logic      slot_free;
    logic      accept;
    logic      is_high;
    tally_t    tally_inc;
    fill_t     fill_after;
    logic      drop_after;
    logic      consume;
    logic      issue;

    spp_high_buf u_high_buf (
        .clk     (clk),
        .ctrl    (buf_ctrl),
        .wr_data (items.sample),
        .rd_data (rd_data)
    );

    assign slot_free  = !out_valid_reg || results.ready;
    assign items.ready = (state_reg == ST_RUN) && slot_free;
    assign accept     = items.valid && items.ready;
    assign is_high    = items.sample > pivot_reg;
    assign tally_inc  = (tally_reg == TallyMax) ? tally_reg : tally_reg + TALLY_W'(1);
    assign fill_after = (fill_reg < FillMax) ? fill_reg + FILL_W'(1) : fill_reg;
    assign drop_after = drop_reg || (fill_reg == FillMax);

    // Reads and writes never overlap: writes happen in RUN, reads in FLUSH.
    assign consume = (state_reg == ST_FLUSH) && pend_reg && slot_free;
    assign issue   = (state_reg == ST_FLUSH) && (rd_idx_reg < fill_reg)
                     && (!pend_reg || consume);

    always_comb
    begin
        buf_ctrl.wr_en   = accept && is_high && (fill_reg < FillMax);
        buf_ctrl.wr_addr = fill_reg[ADDR_W-1:0];
        buf_ctrl.rd_en   = issue;
        buf_ctrl.rd_addr = rd_idx_reg[ADDR_W-1:0];
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        pivot_next     = pivot_reg;
        fill_next      = fill_reg;
        tally_next     = tally_reg;
        drop_next      = drop_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_elem_next  = out_elem_reg;
        out_above_next = out_above_reg;
        out_end_next   = out_end_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;

        if (cfg.valid)
        begin
            pivot_next = cfg.pivot;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (is_high)
                    begin
                        fill_next = fill_after;
                        drop_next = drop_after;
                        if (items.final_item)
                        begin
                            state_next  = ST_FLUSH;
                            rd_idx_next = '0;
                            pend_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        tally_next     = tally_inc;
                        out_valid_next = 1'b1;
                        out_elem_next  = items.sample;
                        out_above_next = 1'b0;
                        out_end_next   = items.final_item && (fill_reg == '0);
                        out_total_next = out_end_next ? tally_inc : '0;
                        out_ovf_next   = out_end_next && drop_reg;
                        if (items.final_item)
                        begin
                            if (fill_reg == '0)
                            begin
                                // Array done: start the next one clean
                                tally_next = '0;
                                drop_next  = 1'b0;
                            end
                            else
                            begin
                                state_next  = ST_FLUSH;
                                rd_idx_next = '0;
                                pend_next   = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (consume)
                begin
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_elem_next  = rd_data;
                    out_above_next = 1'b1;
                    out_end_next   = pend_last_reg;
                    out_total_next = pend_last_reg ? tally_reg : '0;
                    out_ovf_next   = pend_last_reg && drop_reg;
                    if (pend_last_reg)
                    begin
                        state_next  = ST_RUN;
                        fill_next   = '0;
                        tally_next  = '0;
                        drop_next   = 1'b0;
                        rd_idx_next = '0;
                    end
                end
                if (issue)
                begin
                    rd_idx_next    = rd_idx_reg + FILL_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (rd_idx_reg + FILL_W'(1)) == fill_reg;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            pivot_reg     <= '0;
            fill_reg      <= '0;
            tally_reg     <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_elem_reg  <= '0;
            out_above_reg <= 1'b0;
            out_end_reg   <= 1'b0;
            out_total_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pivot_reg     <= pivot_next;
            fill_reg      <= fill_next;
            tally_reg     <= tally_next;
            drop_reg      <= drop_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_elem_reg  <= out_elem_next;
            out_above_reg <= out_above_next;
            out_end_reg   <= out_end_next;
            out_total_reg <= out_total_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.element     = out_elem_reg;
    assign results.above_pivot = out_above_reg;
    assign results.end_of_run  = out_end_reg;
    assign results.low_total   = out_total_reg;
    assign results.overflowed  = out_ovf_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillMax)
        else $error("buffer fill beyond depth");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> fill_reg != '0)
        else $error("flush with empty buffer");

    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> rd_idx_reg <= fill_reg)
        else $error("flush read past fill");

    a_ovf_on_high_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.overflowed |-> results.above_pivot && results.end_of_run)
        else $error("overflow flag on wrong result");

    a_pend_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        consume && pend_last_reg |=> state_reg == ST_RUN && fill_reg == '0)
        else $error("flush did not close the array");
`endif

endmodule

`default_nettype wire
